// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define STT_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("stt assertion failed");

// next-cycle implication
`define STT_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("stt assertion failed");

`endif

// File: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// types and constants shared by the source text tokenizer modules
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int KIND_W = 4;
  localparam int FIELD_W = 16;

  localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_STAR   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_EQ     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LT     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_GT     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_STRING = 4'd8;
  localparam logic [KIND_W-1:0] KIND_TYPE   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [23:0] NAME_INT = "int";
  localparam logic [23:0] NAME_STR = "str";
  localparam logic [23:0] NAME_FUN = "fun";

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

endpackage

// File: rtl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// classifies each text byte, keeps the scan state and builds token entries
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int POS_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          text_byte,
  input  logic                text_valid,
  output logic                text_ready,
  input  logic                q_full,
  output logic                push,
  output stt_pkg::entry_t     push_entry
);

  logic [1:0]           mode, mode_next;
  logic [POS_WIDTH-1:0] pos, pos_next;
  logic [POS_WIDTH-1:0] tstart, tstart_next;
  logic [POS_WIDTH-1:0] runlen, runlen_next;
  logic [23:0]          first3, first3_next;

  logic                 is_letter, is_alnum, single_v, idle_scan, is_type;
  logic [stt_pkg::KIND_W-1:0] single_kind;
  logic [POS_WIDTH-1:0] run_ext;
  logic [23:0]          first_ext;
  logic                 tok_a_v, tok_b_v;
  stt_pkg::token_t      tok_a, tok_b;
  logic                 accept;

  assign text_ready = !q_full;
  assign accept = text_valid && text_ready;

  always_comb begin
    is_letter = text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    is_alnum = is_letter || (text_byte inside {[8'h30:8'h39]});
    single_v = 1'b1;
    case (text_byte)
      stt_pkg::CH_SEMI:  single_kind = stt_pkg::KIND_SEMI;
      stt_pkg::CH_PLUS:  single_kind = stt_pkg::KIND_PLUS;
      stt_pkg::CH_MINUS: single_kind = stt_pkg::KIND_MINUS;
      stt_pkg::CH_STAR:  single_kind = stt_pkg::KIND_STAR;
      stt_pkg::CH_SLASH: single_kind = stt_pkg::KIND_SLASH;
      stt_pkg::CH_EQ:    single_kind = stt_pkg::KIND_EQ;
      stt_pkg::CH_LT:    single_kind = stt_pkg::KIND_LT;
      stt_pkg::CH_GT:    single_kind = stt_pkg::KIND_GT;
      default: begin
        single_kind = stt_pkg::KIND_SEMI;
        single_v = 1'b0;
      end
    endcase
  end

  // run extension with saturating length
  assign run_ext = (runlen == '1) ? runlen : runlen + POS_WIDTH'(1);
  assign first_ext = (runlen < POS_WIDTH'(3)) ? {first3[15:0], text_byte} : first3;
  assign is_type = (runlen == POS_WIDTH'(3)) &&
                   (first3 == stt_pkg::NAME_INT || first3 == stt_pkg::NAME_STR ||
                    first3 == stt_pkg::NAME_FUN);

  always_comb begin
    mode_next = mode;
    tstart_next = tstart;
    runlen_next = runlen;
    first3_next = first3;
    tok_a_v = 1'b0;
    tok_b_v = 1'b0;
    tok_a = '0;
    tok_b = '0;
    idle_scan = 1'b0;
    case (mode)
      stt_pkg::MODE_IDENT: begin
        if (is_alnum) begin
          runlen_next = run_ext;
          first3_next = first_ext;
        end else begin
          tok_a_v = 1'b1;
          tok_a.kind = is_type ? stt_pkg::KIND_TYPE : stt_pkg::KIND_IDENT;
          tok_a.start = stt_pkg::FIELD_W'(tstart);
          tok_a.len = stt_pkg::FIELD_W'(runlen);
          mode_next = stt_pkg::MODE_IDLE;
          idle_scan = (text_byte != stt_pkg::CH_NUL);
        end
      end
      stt_pkg::MODE_STRING: begin
        if (is_alnum) begin
          runlen_next = run_ext;
          first3_next = first_ext;
        end else begin
          tok_a_v = 1'b1;
          tok_a.kind = stt_pkg::KIND_STRING;
          tok_a.start = stt_pkg::FIELD_W'(tstart);
          tok_a.len = stt_pkg::FIELD_W'(runlen);
          mode_next = stt_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_next = stt_pkg::MODE_IDLE;
        idle_scan = (text_byte != stt_pkg::CH_NUL);
      end
    endcase
    if (idle_scan) begin
      if (single_v) begin
        tok_b_v = 1'b1;
        tok_b.kind = single_kind;
        tok_b.start = stt_pkg::FIELD_W'(pos);
        tok_b.len = '0;
      end else if (text_byte == stt_pkg::CH_QUOTE) begin
        mode_next = stt_pkg::MODE_STRING;
        tstart_next = pos + POS_WIDTH'(1);
        runlen_next = '0;
        first3_next = '0;
      end else if (is_letter) begin
        mode_next = stt_pkg::MODE_IDENT;
        tstart_next = pos;
        runlen_next = POS_WIDTH'(1);
        first3_next = {16'h0000, text_byte};
      end
    end
    if (text_byte == stt_pkg::CH_NUL) begin
      mode_next = stt_pkg::MODE_IDLE;
      pos_next = '0;
    end else begin
      pos_next = pos + POS_WIDTH'(1);
    end
  end

  assign push = accept && (tok_a_v || tok_b_v);
  assign push_entry.two = tok_a_v && tok_b_v;
  assign push_entry.tok0 = tok_a_v ? tok_a : tok_b;
  assign push_entry.tok1 = tok_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stt_pkg::MODE_IDLE;
      pos <= '0;
      tstart <= '0;
      runlen <= '0;
      first3 <= '0;
    end else if (accept) begin
      mode <= mode_next;
      pos <= pos_next;
      tstart <= tstart_next;
      runlen <= runlen_next;
      first3 <= first3_next;
    end
  end

endmodule

// File: rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// small fifo of token entries between the front and the back
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stt_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output stt_pkg::entry_t q_entry
);

  stt_pkg::entry_t               mem [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QUEUE_AW-1:0]  wr_ptr, rd_ptr;
  logic [stt_pkg::QUEUE_AW:0]    count;
  logic                          do_pop;

  assign full = (count == (stt_pkg::QUEUE_AW+1)'(stt_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = mem[rd_ptr];
  assign do_pop = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + stt_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + stt_pkg::QUEUE_AW'(1);
      end
      if (push && !do_pop) begin
        count <= count + (stt_pkg::QUEUE_AW+1)'(1);
      end else if (do_pop && !push) begin
        count <= count - (stt_pkg::QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// output register that sends one or two tokens per queue entry
// ----------------------------------------------------------------------------
module stt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  stt_pkg::entry_t             q_entry,
  output logic                        pop,
  output logic                        token_valid,
  input  logic                        token_ready,
  output logic [stt_pkg::KIND_W-1:0]  token_kind,
  output logic [stt_pkg::FIELD_W-1:0] start_pos,
  output logic [stt_pkg::FIELD_W-1:0] value_len,
  output logic                        last_of_run
);

  logic            held;
  logic            idx;
  stt_pkg::entry_t cur;
  stt_pkg::token_t tok;
  logic            last;
  logic            sent;

  assign tok = idx ? cur.tok1 : cur.tok0;
  assign last = !cur.two || idx;
  assign sent = held && token_ready;
  assign pop = q_valid && (!held || (sent && last));

  assign token_valid = held;
  assign token_kind = tok.kind;
  assign start_pos = tok.start;
  assign value_len = tok.len;
  assign last_of_run = last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx <= 1'b0;
    end else if (pop) begin
      held <= 1'b1;
      idx <= 1'b0;
    end else if (sent) begin
      if (last) begin
        held <= 1'b0;
      end else begin
        idx <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// streaming tokenizer for ascii source text
// ----------------------------------------------------------------------------
// Accepts one text byte every cycle while its four-entry token queue has room;
// a byte is classified and the scan state updated in the cycle it is taken.
// Tokens leave through a registered output, one token per cycle while the
// receiver holds token_ready high, so a byte that closes an identifier and is
// itself an operator gives two tokens and holds the output for both. The
// sustained rate is therefore one byte per cycle as long as such double-token
// bytes stay sparse and the output side keeps up; the shared output port sets it.
module source_text_tokenizer #(
  parameter int POS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_byte,
  input  logic        text_valid,
  output logic        text_ready,
  output logic [3:0]  token_kind,
  output logic [15:0] start_pos,
  output logic [15:0] value_len,
  output logic        last_of_run,
  output logic        token_valid,
  input  logic        token_ready
);

  logic            push, full, pop, q_valid;
  stt_pkg::entry_t push_entry, q_entry;

  stt_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .text_byte  (text_byte),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .q_full     (full),
    .push       (push),
    .push_entry (push_entry)
  );

  stt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  stt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .pop         (pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_kind  (token_kind),
    .start_pos   (start_pos),
    .value_len   (value_len),
    .last_of_run (last_of_run)
  );

endmodule

// File: rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// port-level checks on the tokenizer output, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stt_checker (
  input logic        clk,
  input logic        rst,
  input logic [3:0]  token_kind,
  input logic [15:0] start_pos,
  input logic [15:0] value_len,
  input logic        last_of_run,
  input logic        token_valid,
  input logic        token_ready
);

  // stalled transaction keeps valid
  `STT_ASSERT_NEXT(a_valid_hold, token_valid && !token_ready, token_valid)

  // stalled transaction keeps its payload
  `STT_ASSERT_NEXT(a_payload_hold, token_valid && !token_ready,
                   $stable({token_kind, start_pos, value_len, last_of_run}))

  // single-character tokens carry no length
  `STT_ASSERT_NOW(a_single_len, token_valid && token_kind < stt_pkg::KIND_STRING, value_len == '0)

  // a token that is not last of its byte is an identifier or type name
  `STT_ASSERT_NOW(a_first_of_two, token_valid && !last_of_run,
                  (token_kind == stt_pkg::KIND_IDENT) || (token_kind == stt_pkg::KIND_TYPE))

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

// File: tb/source_text_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb
// streams ascii text into the tokenizer and checks every token it emits
// ----------------------------------------------------------------------------
// Each accepted byte runs through a scan model kept in the testbench, which
// queues the tokens that byte should produce. Every emitted token is compared
// field by field against the oldest queued one. Directed text covers each
// operator, type names, identifier and string endings, empty strings and end
// of text. Random program-like text with noise follows. Both sides insert
// random wait cycles, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_rec_t;

  logic        clk;
  logic        rst;
  logic [7:0]  text_byte;
  logic        text_valid;
  logic        text_ready;
  logic [3:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] value_len;
  logic        last_of_run;
  logic        token_valid;
  logic        token_ready;

  token_rec_t expected_tokens[$];
  token_rec_t found[$];
  int         errors;
  int         sent_count;
  bit         sender_burst;
  bit         receiver_burst;

  // scan state of the model
  logic [1:0]  scan_mode;
  logic [15:0] byte_pos;
  logic [15:0] tok_start;
  logic [15:0] run_len;
  logic [23:0] head_chars;

  source_text_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .text_byte(text_byte),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .token_kind(token_kind),
    .start_pos(start_pos),
    .value_len(value_len),
    .last_of_run(last_of_run),
    .token_valid(token_valid),
    .token_ready(token_ready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit is_alnum(input logic [7:0] b);
    return is_letter(b) || (b >= "0" && b <= "9");
  endfunction

  function automatic bit op_token(input logic [7:0] b, output logic [3:0] k);
    op_token = 1'b1;
    case (b)
      stt_pkg::CH_SEMI:  k = stt_pkg::KIND_SEMI;
      stt_pkg::CH_PLUS:  k = stt_pkg::KIND_PLUS;
      stt_pkg::CH_MINUS: k = stt_pkg::KIND_MINUS;
      stt_pkg::CH_STAR:  k = stt_pkg::KIND_STAR;
      stt_pkg::CH_SLASH: k = stt_pkg::KIND_SLASH;
      stt_pkg::CH_EQ:    k = stt_pkg::KIND_EQ;
      stt_pkg::CH_LT:    k = stt_pkg::KIND_LT;
      stt_pkg::CH_GT:    k = stt_pkg::KIND_GT;
      default: begin
        k = stt_pkg::KIND_SEMI;
        op_token = 1'b0;
      end
    endcase
  endfunction

  task automatic grow_run(input logic [7:0] b);
    if (run_len < 16'd3) head_chars = {head_chars[15:0], b};
    if (run_len != 16'hFFFF) run_len = run_len + 16'd1;
  endtask

  task automatic open_token(input logic [7:0] b, input logic [15:0] pos);
    logic [3:0] k;
    if (op_token(b, k)) begin
      found.push_back('{kind: k, start: pos, len: 16'd0, last: 1'b0});
    end else if (b == stt_pkg::CH_QUOTE) begin
      scan_mode = stt_pkg::MODE_STRING;
      tok_start = pos + 16'd1;
      run_len = 16'd0;
      head_chars = 24'd0;
    end else if (is_letter(b)) begin
      scan_mode = stt_pkg::MODE_IDENT;
      tok_start = pos;
      run_len = 16'd0;
      head_chars = 24'd0;
      grow_run(b);
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] b);
    logic [15:0] pos;
    logic [3:0]  k;
    pos = byte_pos;
    found.delete();
    if (scan_mode == stt_pkg::MODE_IDENT) begin
      if (is_alnum(b)) begin
        grow_run(b);
      end else begin
        k = stt_pkg::KIND_IDENT;
        if (run_len == 16'd3 &&
            (head_chars == stt_pkg::NAME_INT || head_chars == stt_pkg::NAME_STR ||
             head_chars == stt_pkg::NAME_FUN))
          k = stt_pkg::KIND_TYPE;
        found.push_back('{kind: k, start: tok_start, len: run_len, last: 1'b0});
        scan_mode = stt_pkg::MODE_IDLE;
        if (b != stt_pkg::CH_NUL) open_token(b, pos);
      end
    end else if (scan_mode == stt_pkg::MODE_STRING) begin
      if (is_alnum(b)) begin
        grow_run(b);
      end else begin
        found.push_back('{kind: stt_pkg::KIND_STRING, start: tok_start, len: run_len,
                          last: 1'b0});
        scan_mode = stt_pkg::MODE_IDLE;
      end
    end else begin
      scan_mode = stt_pkg::MODE_IDLE;
      if (b != stt_pkg::CH_NUL) open_token(b, pos);
    end
    if (b == stt_pkg::CH_NUL) begin
      scan_mode = stt_pkg::MODE_IDLE;
      byte_pos = 16'd0;
    end else begin
      byte_pos = pos + 16'd1;
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) expected_tokens.push_back(found[i]);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // predict on accepted bytes, then check accepted tokens
  always @(posedge clk) begin : token_check
    token_rec_t want;
    if (!rst) begin
      if (text_valid && text_ready) tokenize_byte(text_byte);
      if (token_valid && token_ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d start %0d len %0d",
                                    token_kind, start_pos, value_len));
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind !== want.kind)
            report_mismatch($sformatf("token_kind got %0d want %0d", token_kind, want.kind));
          if (start_pos !== want.start)
            report_mismatch($sformatf("start_pos got %0d want %0d", start_pos, want.start));
          if (value_len !== want.len)
            report_mismatch($sformatf("value_len got %0d want %0d", value_len, want.len));
          if (last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run got %0d want %0d", last_of_run, want.last));
        end
      end
    end
  end

  // token sink with random stalls
  initial begin
    token_ready = 1'b0;
    wait (!rst);
    forever begin : sink_loop
      int stall;
      @(negedge clk);
      stall = receiver_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        token_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      token_ready <= 1'b1;
      do @(posedge clk); while (!token_valid);
    end
  end

  // entered and left just after a falling edge
  task automatic send_text_byte(input logic [7:0] b);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_byte <= b;
    text_valid <= 1'b1;
    do @(posedge clk); while (!text_ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_text_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + (r - 26));
  endfunction

  function automatic logic [7:0] rand_alnum();
    int unsigned r;
    r = $urandom_range(0, 61);
    if (r < 52) return (r < 26) ? 8'("A" + r) : 8'("a" + (r - 26));
    return 8'("0" + (r - 52));
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 7))
      0: return stt_pkg::CH_SEMI;
      1: return stt_pkg::CH_PLUS;
      2: return stt_pkg::CH_MINUS;
      3: return stt_pkg::CH_STAR;
      4: return stt_pkg::CH_SLASH;
      5: return stt_pkg::CH_EQ;
      6: return stt_pkg::CH_LT;
      default: return stt_pkg::CH_GT;
    endcase
  endfunction

  task automatic test_single_char_tokens();
    send_text(";+-*/=<>");
    send_text_byte(8'hFF);
  endtask

  task automatic test_identifiers();
    // type name closed by an operator gives two tokens
    send_text("int;");
    send_text("Q7");
    send_text_byte(8'h80);
  endtask

  task automatic test_strings();
    send_text("\"\"");
    send_text("\"A0");
    send_text_byte(stt_pkg::CH_NUL);
  endtask

  task automatic test_random_text();
    int first;
    int unsigned pick;
    first = sent_count;
    while (sent_count - first < 450) begin
      if ($urandom_range(0, 15) == 0) sender_burst = !sender_burst;
      if ($urandom_range(0, 15) == 0) receiver_burst = !receiver_burst;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        case ($urandom_range(0, 5))
          0: send_text("int");
          1: send_text("str");
          2: send_text("fun");
          3: send_text("Int");
          4: send_text("strx");
          default: send_text("fu");
        endcase
      end else if (pick < 30) begin
        send_text_byte(rand_letter());
        repeat ($urandom_range(0, 6)) send_text_byte(rand_alnum());
      end else if (pick < 48) begin
        send_text_byte(stt_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 6)) send_text_byte(rand_alnum());
        send_text_byte(8'($urandom_range(0, 255)));
      end else if (pick < 68) begin
        send_text_byte(rand_operator());
      end else if (pick < 78) begin
        send_text_byte(" ");
      end else if (pick < 83) begin
        send_text_byte(stt_pkg::CH_NUL);
      end else begin
        send_text_byte(8'($urandom_range(0, 255)));
      end
    end
    sender_burst = 1'b0;
    receiver_burst = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    text_valid = 1'b0;
    text_byte = stt_pkg::CH_NUL;
    errors = 0;
    sent_count = 0;
    sender_burst = 1'b0;
    receiver_burst = 1'b0;
    scan_mode = stt_pkg::MODE_IDLE;
    byte_pos = 16'd0;
    tok_start = 16'd0;
    run_len = 16'd0;
    head_chars = 24'd0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_single_char_tokens();
    test_identifiers();
    test_strings();
    test_random_text();
    text_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
